// ===== hw/rtl/tdj_pkg.sv =====
// ----------------------------------------------------------------------------
// tdj_pkg
// Shared constants and types for the triangle deformation operator pipeline.
// ----------------------------------------------------------------------------
package tdj_pkg;

    // capped quotient bits of each coefficient divide; sqrt of that fits MAG_W
    localparam int QUO_W    = 62;
    localparam int MAG_W    = 31;
    localparam int COEF_W   = 32;
    // stages inside one coefficient unit: load/overflow, divide, square root
    localparam int COEF_LAT = 1 + QUO_W + MAG_W;

    localparam logic [COEF_W-1:0] COEF_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [COEF_W-1:0] COEF_NEG_MIN = 32'h8000_0000;

    typedef struct packed {
        logic deg;
        logic neg_x1;
        logic neg_p;
    } tdj_flags_t;

endpackage

// ===== hw/rtl/tdj_coef.sv =====
// ----------------------------------------------------------------------------
// tdj_coef
// Pipelined magnitude unit: floor(sqrt(a / b)) with an overflow flag when the
// root reaches 2^MAG_W. Restoring divide, one quotient bit a stage, then a
// restoring square root, one root bit a stage.
// ----------------------------------------------------------------------------
module tdj_coef #(
    parameter int WA = 97,
    parameter int WB = 66
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic [WA-1:0]              a,
    input  logic [WB-1:0]              b,
    output logic [tdj_pkg::MAG_W-1:0]  mag,
    output logic                       ovf
);

    localparam int QW = tdj_pkg::QUO_W;
    localparam int MW = tdj_pkg::MAG_W;
    localparam int WR = (WA > WB + QW) ? WA : WB + QW;

    logic [WR-1:0] rem_reg [0:QW-1];
    logic [WB-1:0] div_reg [0:QW-1];
    logic [QW-1:0] quo_reg [0:QW];
    logic          ovf_reg [0:QW+MW];
    logic [QW-1:0] rr_reg   [0:MW-1];
    logic [MW-1:0] root_reg [0:MW-1];

    // quotient of 2^QW or more means root of 2^MW or more
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= WR'(a);
            div_reg[0] <= b;
            quo_reg[0] <= '0;
            ovf_reg[0] <= (WR'(a) >= (WR'(b) << QW));
        end
    end

    for (genvar j = 0; j < QW; j++)
    begin : g_div
        localparam int K = QW - 1 - j;
        logic [WR-1:0] trial;
        logic          take;

        assign trial = WR'(div_reg[j]) << K;
        assign take  = (rem_reg[j] >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[j+1] <= take ? (quo_reg[j] | (QW'(1) << K)) : quo_reg[j];
                ovf_reg[j+1] <= ovf_reg[j];
            end
        end

        if (j < QW - 1)
        begin : g_fwd
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j+1] <= take ? (rem_reg[j] - trial) : rem_reg[j];
                    div_reg[j+1] <= div_reg[j];
                end
            end
        end
    end

    for (genvar m = 0; m < MW; m++)
    begin : g_sqrt
        localparam int I = MW - 1 - m;
        logic [QW-1:0] src_rem;
        logic [MW-1:0] src_root;
        logic [QW-1:0] trial;

        if (m == 0)
        begin : g_first
            assign src_rem  = quo_reg[QW];
            assign src_root = '0;
        end
        else
        begin : g_next
            assign src_rem  = rr_reg[m-1];
            assign src_root = root_reg[m-1];
        end

        // (R + 2^I)^2 - R^2, root bits sit above I
        assign trial = (QW'(src_root) << (I + 1)) | (QW'(1) << (2 * I));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (src_rem >= trial)
                begin
                    rr_reg[m]   <= src_rem - trial;
                    root_reg[m] <= src_root | (MW'(1) << I);
                end
                else
                begin
                    rr_reg[m]   <= src_rem;
                    root_reg[m] <= src_root;
                end
                ovf_reg[QW+1+m] <= ovf_reg[QW+m];
            end
        end
    end

    assign mag = root_reg[MW-1];
    assign ovf = ovf_reg[QW+MW];

endmodule

// ===== hw/rtl/triangle_deformation_jacobian.sv =====
// ----------------------------------------------------------------------------
// triangle_deformation_jacobian
// Constant strain triangle operator: three rest vertices in, six coefficients
// of B = (D * inv(dX))^T out, with a degenerate flag.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one triangle per beat as nine
//   signed fixed point coordinates. Output channel (out_valid/out_ready)
//   returns one beat per triangle, in order: valid_res and six coefficients.
//   cfg_wr_en/cfg_wr_data loads the degenerate threshold; write it only while
//   the pipeline is empty.
// Throughput: one triangle per cycle while out_ready stays high.
// Pipeline: the edge/product front end (10 stages), then the bit-per-stage
//   divide and square root of the coefficient units, then the output
//   register that drives out_valid.
// Stall: the whole pipeline holds when a result waits and out_ready is low;
//   bubbles keep moving while the output register is empty. Nothing is lost.
// Reset: clears all valid bits and the threshold to zero; payload registers
//   are not reset.
// ----------------------------------------------------------------------------
module triangle_deformation_jacobian #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [30:0]        cfg_wr_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] p0_x,
    input  logic signed [31:0] p0_y,
    input  logic signed [31:0] p0_z,
    input  logic signed [31:0] p1_x,
    input  logic signed [31:0] p1_y,
    input  logic signed [31:0] p1_z,
    input  logic signed [31:0] p2_x,
    input  logic signed [31:0] p2_y,
    input  logic signed [31:0] p2_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               valid_res,
    output logic signed [31:0] coef_r0_c0,
    output logic signed [31:0] coef_r0_c1,
    output logic signed [31:0] coef_r0_c2,
    output logic signed [31:0] coef_r1_c0,
    output logic signed [31:0] coef_r1_c1,
    output logic signed [31:0] coef_r1_c2
);

    localparam int F4      = 4 * FRAC_BITS;
    localparam int S_W     = 66;
    localparam int Q_W     = 132;
    localparam int SQ_W    = 198;
    localparam int X1SQ_W  = 134;
    localparam int PSQ_W   = 132;
    localparam int HALF_W  = 165;
    localparam int MW      = tdj_pkg::MAG_W;
    localparam int LAT     = tdj_pkg::COEF_LAT;
    localparam int N_FRONT = 10;
    localparam int N_PIPE  = N_FRONT + LAT;

    logic adv;
    logic [1:N_PIPE] vld_reg;
    logic out_valid_reg;

    logic [30:0] thr_reg;
    logic [61:0] thr_sq_reg;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // ---------------- control ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
            thr_reg       <= '0;
            thr_sq_reg    <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                thr_reg <= cfg_wr_data;
            end
            thr_sq_reg <= 62'(thr_reg) * 62'(thr_reg);
            if (adv)
            begin
                vld_reg[1] <= in_valid;
                for (int i = 2; i <= N_PIPE; i++)
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
                out_valid_reg <= vld_reg[N_PIPE];
            end
        end
    end

    // ---------------- front end datapath ----------------
    logic signed [31:0] v0 [3];
    logic signed [31:0] v1 [3];
    logic signed [31:0] v2 [3];

    assign v0[0] = p0_x; assign v0[1] = p0_y; assign v0[2] = p0_z;
    assign v1[0] = p1_x; assign v1[1] = p1_y; assign v1[2] = p1_z;
    assign v2[0] = p2_x; assign v2[1] = p2_y; assign v2[2] = p2_z;

    logic signed [32:0] e0_reg [3];
    logic signed [32:0] e1_reg [3];
    logic signed [65:0] ss_reg [3];
    logic signed [65:0] dd_reg [3];
    logic signed [65:0] ca_reg [3];
    logic signed [65:0] cb_reg [3];
    logic [S_W-1:0]     s3_s_reg;
    logic signed [66:0] s3_p_reg;
    logic signed [65:0] s3_c_reg [3];
    logic [67:0]        mag_reg [5];     // |c0| |c1| |c2| |x1| |P|
    logic [S_W-1:0]     s4_s_reg;
    logic               s4_neg_x1_reg;
    logic               s4_neg_p_reg;
    logic [67:0]        hh_reg [5];
    logic [67:0]        hl_reg [5];
    logic [67:0]        ll_reg [5];
    logic [S_W-1:0]     s5_s_reg;
    logic               s5_neg_x1_reg;
    logic               s5_neg_p_reg;
    logic [129:0]       csq_reg [3];
    logic [X1SQ_W-1:0]  s6_x1sq_reg;
    logic [PSQ_W-1:0]   s6_psq_reg;
    logic [S_W-1:0]     s6_s_reg;
    logic               s6_neg_x1_reg;
    logic               s6_neg_p_reg;
    logic [Q_W-1:0]     s7_q_reg;
    logic [X1SQ_W-1:0]  s7_x1sq_reg;
    logic [PSQ_W-1:0]   s7_psq_reg;
    logic [S_W-1:0]     s7_s_reg;
    logic               s7_neg_x1_reg;
    logic               s7_neg_p_reg;
    logic [65:0]        pp_reg [2][4];
    logic [Q_W-1:0]     s8_q_reg;
    logic [X1SQ_W-1:0]  s8_x1sq_reg;
    logic [PSQ_W-1:0]   s8_psq_reg;
    logic [S_W-1:0]     s8_s_reg;
    tdj_pkg::tdj_flags_t s8_flags_reg;
    logic [HALF_W-1:0]  half_reg [2];
    logic [Q_W-1:0]     s9_q_reg;
    logic [X1SQ_W-1:0]  s9_x1sq_reg;
    logic [PSQ_W-1:0]   s9_psq_reg;
    logic [S_W-1:0]     s9_s_reg;
    tdj_pkg::tdj_flags_t s9_flags_reg;
    logic [SQ_W-1:0]    s10_sq_reg;
    logic [Q_W-1:0]     s10_q_reg;
    logic [X1SQ_W-1:0]  s10_x1sq_reg;
    logic [PSQ_W-1:0]   s10_psq_reg;
    logic [S_W-1:0]     s10_s_reg;
    tdj_pkg::tdj_flags_t s10_flags_reg;
    tdj_pkg::tdj_flags_t flags_reg [0:LAT-1];

    logic [67:0]  x1_next;
    logic [135:0] sq_next [5];

    assign x1_next = 68'(s3_p_reg) - 68'(s3_s_reg);

    always_comb
    begin
        for (int i = 0; i < 5; i++)
        begin
            sq_next[i] = (136'(hh_reg[i]) << 68) + (136'(hl_reg[i]) << 35)
                       + 136'(ll_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // stage 1: edges
            for (int i = 0; i < 3; i++)
            begin
                e0_reg[i] <= 33'(v1[i]) - 33'(v0[i]);
                e1_reg[i] <= 33'(v2[i]) - 33'(v0[i]);
            end
            // stage 2: products for S, P and the cross product
            for (int i = 0; i < 3; i++)
            begin
                ss_reg[i] <= 66'(e0_reg[i]) * 66'(e0_reg[i]);
                dd_reg[i] <= 66'(e0_reg[i]) * 66'(e1_reg[i]);
                ca_reg[i] <= 66'(e0_reg[(i+1)%3]) * 66'(e1_reg[(i+2)%3]);
                cb_reg[i] <= 66'(e0_reg[(i+2)%3]) * 66'(e1_reg[(i+1)%3]);
            end
            // stage 3: sums
            s3_s_reg <= S_W'(ss_reg[0]) + S_W'(ss_reg[1]) + S_W'(ss_reg[2]);
            s3_p_reg <= 67'(dd_reg[0]) + 67'(dd_reg[1]) + 67'(dd_reg[2]);
            for (int i = 0; i < 3; i++)
            begin
                s3_c_reg[i] <= ca_reg[i] - cb_reg[i];
            end
            // stage 4: magnitudes and signs, x1 = P - S
            for (int i = 0; i < 3; i++)
            begin
                mag_reg[i] <= s3_c_reg[i][65] ? 68'(-s3_c_reg[i]) : 68'(s3_c_reg[i]);
            end
            mag_reg[3]    <= x1_next[67] ? (68'(0) - x1_next) : x1_next;
            mag_reg[4]    <= s3_p_reg[66] ? 68'(-s3_p_reg) : 68'(s3_p_reg);
            s4_s_reg      <= s3_s_reg;
            s4_neg_x1_reg <= x1_next[67];
            s4_neg_p_reg  <= !s3_p_reg[66];
            // stage 5: square partial products, 34-bit halves
            for (int i = 0; i < 5; i++)
            begin
                hh_reg[i] <= 68'(mag_reg[i][67:34]) * 68'(mag_reg[i][67:34]);
                hl_reg[i] <= 68'(mag_reg[i][67:34]) * 68'(mag_reg[i][33:0]);
                ll_reg[i] <= 68'(mag_reg[i][33:0]) * 68'(mag_reg[i][33:0]);
            end
            s5_s_reg      <= s4_s_reg;
            s5_neg_x1_reg <= s4_neg_x1_reg;
            s5_neg_p_reg  <= s4_neg_p_reg;
            // stage 6: squares
            for (int i = 0; i < 3; i++)
            begin
                csq_reg[i] <= sq_next[i][129:0];
            end
            s6_x1sq_reg   <= sq_next[3][X1SQ_W-1:0];
            s6_psq_reg    <= sq_next[4][PSQ_W-1:0];
            s6_s_reg      <= s5_s_reg;
            s6_neg_x1_reg <= s5_neg_x1_reg;
            s6_neg_p_reg  <= s5_neg_p_reg;
            // stage 7: squared cross norm
            s7_q_reg      <= Q_W'(csq_reg[0]) + Q_W'(csq_reg[1]) + Q_W'(csq_reg[2]);
            s7_x1sq_reg   <= s6_x1sq_reg;
            s7_psq_reg    <= s6_psq_reg;
            s7_s_reg      <= s6_s_reg;
            s7_neg_x1_reg <= s6_neg_x1_reg;
            s7_neg_p_reg  <= s6_neg_p_reg;
            // stage 8: S*Q partial products, degenerate test
            for (int j = 0; j < 4; j++)
            begin
                pp_reg[0][j] <= 66'(s7_s_reg[32:0]) * 66'(s7_q_reg[33*j +: 33]);
                pp_reg[1][j] <= 66'(s7_s_reg[65:33]) * 66'(s7_q_reg[33*j +: 33]);
            end
            s8_flags_reg.deg    <= (s7_q_reg == '0) ||
                                   (s7_q_reg < (Q_W'(thr_sq_reg) << (2 * FRAC_BITS)));
            s8_flags_reg.neg_x1 <= s7_neg_x1_reg;
            s8_flags_reg.neg_p  <= s7_neg_p_reg;
            s8_q_reg            <= s7_q_reg;
            s8_x1sq_reg         <= s7_x1sq_reg;
            s8_psq_reg          <= s7_psq_reg;
            s8_s_reg            <= s7_s_reg;
            // stage 9: partial sums per half of S
            for (int h = 0; h < 2; h++)
            begin
                half_reg[h] <= HALF_W'(pp_reg[h][0])
                             + (HALF_W'(pp_reg[h][1]) << 33)
                             + (HALF_W'(pp_reg[h][2]) << 66)
                             + (HALF_W'(pp_reg[h][3]) << 99);
            end
            s9_q_reg     <= s8_q_reg;
            s9_x1sq_reg  <= s8_x1sq_reg;
            s9_psq_reg   <= s8_psq_reg;
            s9_s_reg     <= s8_s_reg;
            s9_flags_reg <= s8_flags_reg;
            // stage 10: S*Q
            s10_sq_reg    <= SQ_W'(half_reg[0]) + (SQ_W'(half_reg[1]) << 33);
            s10_q_reg     <= s9_q_reg;
            s10_x1sq_reg  <= s9_x1sq_reg;
            s10_psq_reg   <= s9_psq_reg;
            s10_s_reg     <= s9_s_reg;
            s10_flags_reg <= s9_flags_reg;
            // flags ride alongside the coefficient units
            flags_reg[0] <= s10_flags_reg;
            for (int i = 1; i < LAT; i++)
            begin
                flags_reg[i] <= flags_reg[i-1];
            end
        end
    end

    // ---------------- coefficient units ----------------
    logic [MW-1:0] mag_a, mag_b, mag_c, mag_d;
    logic          ovf_a, ovf_b, ovf_c, ovf_d;

    // row 0: 2^(4F) / S
    tdj_coef #(.WA(F4 + 1), .WB(S_W)) u_coef_a (
        .clk (clk),
        .en  (adv),
        .a   ((F4 + 1)'(1) << F4),
        .b   (s10_s_reg),
        .mag (mag_a),
        .ovf (ovf_a)
    );

    // row 1 col 0: x1^2 * 2^(4F) / (S*Q)
    tdj_coef #(.WA(X1SQ_W + F4), .WB(SQ_W)) u_coef_b (
        .clk (clk),
        .en  (adv),
        .a   ((X1SQ_W + F4)'(s10_x1sq_reg) << F4),
        .b   (s10_sq_reg),
        .mag (mag_b),
        .ovf (ovf_b)
    );

    // row 1 col 1: P^2 * 2^(4F) / (S*Q)
    tdj_coef #(.WA(PSQ_W + F4), .WB(SQ_W)) u_coef_c (
        .clk (clk),
        .en  (adv),
        .a   ((PSQ_W + F4)'(s10_psq_reg) << F4),
        .b   (s10_sq_reg),
        .mag (mag_c),
        .ovf (ovf_c)
    );

    // row 1 col 2: S^2/(S*Q) reduces to S * 2^(4F) / Q
    tdj_coef #(.WA(S_W + F4), .WB(Q_W)) u_coef_d (
        .clk (clk),
        .en  (adv),
        .a   ((S_W + F4)'(s10_s_reg) << F4),
        .b   (s10_q_reg),
        .mag (mag_d),
        .ovf (ovf_d)
    );

    function automatic logic [31:0] sat_coef(input logic [MW-1:0] mag,
                                             input logic ovf,
                                             input logic neg);
        logic [31:0] r;
        if (neg)
        begin
            r = ovf ? tdj_pkg::COEF_NEG_MIN : (32'(0) - 32'(mag));
        end
        else
        begin
            r = ovf ? tdj_pkg::COEF_POS_MAX : 32'(mag);
        end
        return r;
    endfunction

    // ---------------- output register ----------------
    tdj_pkg::tdj_flags_t fo;
    logic valid_res_reg;
    logic [31:0] c00_reg, c01_reg, c10_reg, c11_reg, c12_reg;

    assign fo = flags_reg[LAT-1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            valid_res_reg <= !fo.deg;
            c00_reg <= fo.deg ? '0 : sat_coef(mag_a, ovf_a, 1'b1);
            c01_reg <= fo.deg ? '0 : sat_coef(mag_a, ovf_a, 1'b0);
            c10_reg <= fo.deg ? '0 : sat_coef(mag_b, ovf_b, fo.neg_x1);
            c11_reg <= fo.deg ? '0 : sat_coef(mag_c, ovf_c, fo.neg_p);
            c12_reg <= fo.deg ? '0 : sat_coef(mag_d, ovf_d, 1'b0);
        end
    end

    assign out_valid  = out_valid_reg;
    assign valid_res  = valid_res_reg;
    assign coef_r0_c0 = c00_reg;
    assign coef_r0_c1 = c01_reg;
    assign coef_r0_c2 = '0;
    assign coef_r1_c0 = c10_reg;
    assign coef_r1_c1 = c11_reg;
    assign coef_r1_c2 = c12_reg;

endmodule

// ===== hw/rtl/tdj_checker.sv =====
// ----------------------------------------------------------------------------
// tdj_checker
// Port-level checks for the triangle operator, bound to the top level.
// ----------------------------------------------------------------------------
module tdj_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic               valid_res,
    input logic signed [31:0] coef_r0_c0,
    input logic signed [31:0] coef_r0_c1,
    input logic signed [31:0] coef_r0_c2,
    input logic signed [31:0] coef_r1_c0,
    input logic signed [31:0] coef_r1_c1,
    input logic signed [31:0] coef_r1_c2
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(valid_res)
            && $stable(coef_r0_c0) && $stable(coef_r0_c1)
            && $stable(coef_r1_c0) && $stable(coef_r1_c1) && $stable(coef_r1_c2)))
        else $error("result beat changed while stalled");

    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !valid_res) |-> (coef_r0_c0 == 0 && coef_r0_c1 == 0
            && coef_r0_c2 == 0 && coef_r1_c0 == 0 && coef_r1_c1 == 0
            && coef_r1_c2 == 0))
        else $error("degenerate triangle with nonzero coefficients");

    // row 0 is (-m, m, 0), apart from the saturated pair; row 1 col 2 is not negative
    a_row0: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && valid_res) |-> (coef_r0_c2 == 0
            && ((32'(coef_r0_c0 + coef_r0_c1) == 32'd0)
                || (coef_r0_c0 == 32'sh8000_0000 && coef_r0_c1 == 32'sh7FFF_FFFF))
            && !coef_r1_c2[31]))
        else $error("row 0 coefficients inconsistent");

    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output register");

endmodule

bind triangle_deformation_jacobian tdj_checker u_tdj_checker (.*);

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for triangle_deformation_jacobian: random and directed
// triangles under random stalls on both channels, each output beat compared
// against an exact wide-integer predictor of the six operator coefficients.
// ----------------------------------------------------------------------------
module tb;

    localparam int FRAC_BITS  = 16;
    localparam int PIPE_DRAIN = 120;
    localparam int CYCLE_MAX  = 300000;
    localparam int BUSY_PCT   = 38;

    // vertex order: p0 xyz, p1 xyz, p2 xyz
    typedef struct packed {
        logic [8:0][31:0] p;
    } tri_t;

    typedef struct packed {
        logic             ok;
        logic [5:0][31:0] c;
    } jac_t;

    typedef enum int {
        TRI_FULL, TRI_SMALL, TRI_TINY, TRI_COLLINEAR, TRI_DUP, TRI_NEAR
    } tri_kind_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [30:0] cfg_wr_data;
    logic        in_valid;
    logic        in_ready;
    logic [8:0][31:0] vtx;
    logic        out_valid;
    logic        out_ready;
    logic        valid_res;
    logic signed [31:0] coef_r0_c0, coef_r0_c1, coef_r0_c2;
    logic signed [31:0] coef_r1_c0, coef_r1_c1, coef_r1_c2;

    tri_t        tri_pending[$];
    jac_t        jac_expected[$];
    logic [30:0] thr_model;
    logic        in_fire;
    bit          quiet;
    bit          hold_req;
    int          ready_hold;
    int          cycles;
    int          errors;

    triangle_deformation_jacobian #(.FRAC_BITS(FRAC_BITS)) dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .p0_x(vtx[0]), .p0_y(vtx[1]), .p0_z(vtx[2]),
        .p1_x(vtx[3]), .p1_y(vtx[4]), .p1_z(vtx[5]),
        .p2_x(vtx[6]), .p2_y(vtx[7]), .p2_z(vtx[8]),
        .out_valid(out_valid), .out_ready(out_ready),
        .valid_res(valid_res),
        .coef_r0_c0(coef_r0_c0), .coef_r0_c1(coef_r0_c1), .coef_r0_c2(coef_r0_c2),
        .coef_r1_c0(coef_r1_c0), .coef_r1_c1(coef_r1_c1), .coef_r1_c2(coef_r1_c2)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [63:0] isqrt(logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // magnitude is floor(sqrt(num/den)), then signed saturation to 32 bits
    function automatic logic [31:0] coef_of(logic [255:0] num, logic [255:0] den, bit neg);
        logic [255:0] q;
        logic [63:0]  mag;
        q = num / den;
        mag = (q[255:64] != 0) ? (64'd1 << 33) : isqrt(q[63:0]);
        if (!neg)
            return (mag > 64'h7FFF_FFFF) ? tdj_pkg::COEF_POS_MAX : mag[31:0];
        if (mag > 64'h8000_0000)
            mag = 64'h8000_0000;
        return 32'(64'd0 - mag);
    endfunction

    function automatic jac_t jacobian_of(tri_t t, logic [30:0] thr);
        logic signed [255:0] e0 [3];
        logic signed [255:0] e1 [3];
        logic signed [255:0] s, pd, cr, qq, x1;
        logic [255:0] su, qu, x1m, pm, den, thr_q, one;
        jac_t r;
        s = 0;
        pd = 0;
        qq = 0;
        for (int i = 0; i < 3; i++)
        begin
            e0[i] = $signed(t.p[3+i]) - $signed(t.p[i]);
            e1[i] = $signed(t.p[6+i]) - $signed(t.p[i]);
        end
        for (int i = 0; i < 3; i++)
        begin
            s  = s + e0[i] * e0[i];
            pd = pd + e0[i] * e1[i];
            cr = e0[(i+1)%3] * e1[(i+2)%3] - e0[(i+2)%3] * e1[(i+1)%3];
            qq = qq + cr * cr;
        end
        r = '0;
        qu = qq;
        thr_q = 256'(thr);
        thr_q = (thr_q * thr_q) << (2 * FRAC_BITS);
        if (qu == 0 || qu < thr_q)
            return r;
        su  = s;
        one = 256'd1 << (4 * FRAC_BITS);
        x1  = pd - s;
        x1m = (x1 < 0) ? -x1 : x1;
        pm  = (pd < 0) ? -pd : pd;
        den = su * qu;
        r.ok   = 1'b1;
        r.c[0] = coef_of(one, su, 1'b1);
        r.c[1] = coef_of(one, su, 1'b0);
        r.c[2] = '0;
        r.c[3] = coef_of((x1m * x1m) * one, den, x1 < 0);
        r.c[4] = coef_of((pm * pm) * one, den, pd >= 0);
        r.c[5] = coef_of((su * su) * one, den, 1'b0);
        return r;
    endfunction

    function automatic logic [31:0] rnd_span(int bits);
        logic [31:0] v;
        v = $urandom;
        v = v & ((32'd1 << bits) - 1);
        return v - (32'd1 << (bits - 1));
    endfunction

    function automatic tri_t make_tri(tri_kind_t kind);
        tri_t t;
        int   k;
        case (kind)
            TRI_FULL:
                for (int i = 0; i < 9; i++)
                    t.p[i] = $urandom;
            TRI_SMALL:
                for (int i = 0; i < 9; i++)
                    t.p[i] = rnd_span(19);
            TRI_TINY:
                for (int i = 0; i < 9; i++)
                    t.p[i] = rnd_span(7);
            TRI_DUP:
            begin
                for (int i = 0; i < 9; i++)
                    t.p[i] = rnd_span(20);
                k = $urandom_range(2);
                for (int i = 0; i < 3; i++)
                    t.p[3*k+i] = t.p[3*((k+1)%3)+i];
            end
            default:
            begin
                // p2 on the line through p0, p1; near case nudges it off
                k = $urandom_range(7) - 3;
                for (int i = 0; i < 6; i++)
                    t.p[i] = rnd_span(18);
                for (int i = 0; i < 3; i++)
                begin
                    t.p[6+i] = t.p[i] + k * (t.p[3+i] - t.p[i]);
                    if (kind == TRI_NEAR)
                        t.p[6+i] = t.p[6+i] + rnd_span(4);
                end
            end
        endcase
        return t;
    endfunction

    function automatic tri_kind_t pick_kind();
        int r;
        r = $urandom_range(99);
        if (r < 20) return TRI_FULL;
        if (r < 50) return TRI_SMALL;
        if (r < 65) return TRI_TINY;
        if (r < 75) return TRI_COLLINEAR;
        if (r < 80) return TRI_DUP;
        return TRI_NEAR;
    endfunction

    function automatic tri_t tri_of(int a, int b, int c, int d, int e, int f,
                                    int g, int h, int k);
        tri_t t;
        t.p = {k, h, g, f, e, d, c, b, a};
        return t;
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_MAX)
        begin
            $display("** triangle_deformation_jacobian: FAILED **");
            $finish;
        end
    end

    // checker and predictor, both at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        jac_t want;
        if (!rst_n)
            in_fire <= 1'b0;
        else
        begin
            in_fire <= in_valid && in_ready;
            if (out_valid && out_ready)
            begin
                if (jac_expected.size() == 0)
                begin
                    $error("output beat with nothing expected");
                    errors++;
                end
                else
                begin
                    want = jac_expected.pop_front();
                    if (valid_res !== want.ok)
                    begin
                        $error("valid_res exp %0d got %0d", want.ok, valid_res);
                        errors++;
                    end
                    if (coef_r0_c0 !== want.c[0])
                    begin
                        $error("coef_r0_c0 exp %h got %h", want.c[0], coef_r0_c0);
                        errors++;
                    end
                    if (coef_r0_c1 !== want.c[1])
                    begin
                        $error("coef_r0_c1 exp %h got %h", want.c[1], coef_r0_c1);
                        errors++;
                    end
                    if (coef_r0_c2 !== want.c[2])
                    begin
                        $error("coef_r0_c2 exp %h got %h", want.c[2], coef_r0_c2);
                        errors++;
                    end
                    if (coef_r1_c0 !== want.c[3])
                    begin
                        $error("coef_r1_c0 exp %h got %h", want.c[3], coef_r1_c0);
                        errors++;
                    end
                    if (coef_r1_c1 !== want.c[4])
                    begin
                        $error("coef_r1_c1 exp %h got %h", want.c[4], coef_r1_c1);
                        errors++;
                    end
                    if (coef_r1_c2 !== want.c[5])
                    begin
                        $error("coef_r1_c2 exp %h got %h", want.c[5], coef_r1_c2);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready)
                jac_expected.push_back(jacobian_of(vtx, thr_model));
        end
    end

    // driver
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_fire))
        begin
            if (tri_pending.size() > 0 && (quiet || $urandom_range(99) >= BUSY_PCT))
            begin
                vtx      <= tri_pending.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver with its own long hold-off counter
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (ready_hold > 0)
            begin
                ready_hold = ready_hold - 1;
                out_ready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req   = 1'b0;
                ready_hold = 400;
                out_ready <= 1'b0;
            end
            else
                out_ready <= quiet || ($urandom_range(99) >= BUSY_PCT);
        end
    end

    task automatic wait_drained();
        while (tri_pending.size() != 0 || in_valid || jac_expected.size() != 0)
            @(negedge clk);
        repeat (PIPE_DRAIN) @(negedge clk);
    endtask

    task automatic write_thr(logic [30:0] v);
        wait_drained();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = v;
        thr_model   = v;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
    endtask

    task automatic queue_random(int n);
        repeat (n) tri_pending.push_back(make_tri(pick_kind()));
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        out_ready   = 1'b0;
        vtx         = '0;
        thr_model   = '0;
        quiet       = 1'b0;
        hold_req    = 1'b0;
        ready_hold  = 0;
        cycles      = 0;
        errors      = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: zero area, unit and extreme triangles, saturation, signs
        tri_pending.push_back(tri_of(0, 0, 0, 0, 0, 0, 0, 0, 0));
        tri_pending.push_back(tri_of(0, 0, 0, 65536, 0, 0, 0, 65536, 0));
        tri_pending.push_back(tri_of(0, 0, 0, 1, 0, 0, 0, 1, 0));
        tri_pending.push_back(tri_of(0, 0, 0, 1, 0, 0, 0, 0, 1));
        tri_pending.push_back(tri_of(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                     32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
        tri_pending.push_back(tri_of(32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0,
                                     0, 32'h7FFF_FFFF, 32'h8000_0000));
        tri_pending.push_back(tri_of(-1, -1, -1, -1, -1, -1, -1, -1, -1));
        tri_pending.push_back(tri_of(0, 0, 0, 65536, 0, 0, -131072, 65536, 0));
        tri_pending.push_back(tri_of(0, 0, 0, 65536, 0, 0, 196608, 65536, 0));
        tri_pending.push_back(tri_of(0, 0, 0, 65536, 0, 0, 65536, 65536, 0));
        tri_pending.push_back(tri_of(0, 0, 0, 65536, 0, 0, 131072, 0, 0));
        tri_pending.push_back(tri_of(5, 5, 5, 5, 5, 5, 9, 1, 3));
        tri_pending.push_back(tri_of(0, 0, 0, 1 << 30, 0, 0, 0, 1, 0));
        tri_pending.push_back(tri_of(0, 0, 0, 1, 0, 0, 0, 1 << 30, 0));
        tri_pending.push_back(tri_of(0, 0, 0, 0, 0, 65536, 0, 65536, 0));
        repeat (6) tri_pending.push_back(make_tri(TRI_FULL));

        // random phases over several thresholds; first one holds the output
        write_thr(31'd0);
        quiet    = 1'b1;
        @(posedge clk);
        hold_req = 1'b1;
        queue_random(300);
        write_thr(31'h7FFF_FFFF);
        quiet = 1'b0;
        queue_random(200);
        write_thr(31'd1);
        queue_random(200);
        write_thr(31'h0001_0000);
        queue_random(150);
        wait_drained();
        quiet = 1'b1;
        queue_random(150);
        write_thr(31'($urandom_range(32'h0010_0000)));
        quiet = 1'b0;
        queue_random(400);
        wait_drained();

        if (errors == 0)
            $display("** triangle_deformation_jacobian: PASSED **");
        else
            $display("** triangle_deformation_jacobian: FAILED **");
        $finish;
    end

endmodule
